[src/utf8_stream_validator_core_assert.svh]
// Assertion macros for the UTF-8 stream validator core.
`ifndef UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8SV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8SV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/u8sv_pkg.sv]
// Types, constants and helpers for the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8sv_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int ERR_OFS_W   = 16;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Lead bytes needing checks on later bytes, plus BF and NUL.
    localparam logic [7:0] LEAD_E0   = 8'he0;
    localparam logic [7:0] LEAD_ED   = 8'hed;
    localparam logic [7:0] LEAD_EF   = 8'hef;
    localparam logic [7:0] LEAD_F0   = 8'hf0;
    localparam logic [7:0] LEAD_F4   = 8'hf4;
    localparam logic [7:0] CONT_BF   = 8'hbf;
    localparam logic [7:0] BYTE_NUL  = 8'h00;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_VALID = 2'd1,
        ST_ERROR = 2'd2,
        ST_SKIP  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]             rem;
        logic [7:0]             lead;
        logic [7:0]             second;
        logic [OFFSET_BITS-1:0] seq_start;
        logic [OFFSET_BITS-1:0] pos;
        logic                   skipping;
    } t_state;

    typedef struct packed {
        logic [ERR_OFS_W-1:0] error_offset;
        t_status              status;
    } t_result;

    localparam t_state STATE_RESET = '{rem: 2'd0, lead: 8'd0, second: 8'd0,
                                       seq_start: '0, pos: '0, skipping: 1'b0};

    // Saturating position increment.
    function automatic logic [OFFSET_BITS-1:0] adv_pos(input logic [OFFSET_BITS-1:0] p);
        adv_pos = (p == OFFSET_MAX) ? p : p + 1'b1;
    endfunction

endpackage

[src/u8sv_step.sv]
// Per-byte UTF-8 check: next state and status from the held state and one byte.
`timescale 1ns / 1ps

module u8sv_step
    import u8sv_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_result    o_result
);

    logic       bad;
    logic       len3;
    logic       len4;
    logic       idx1;
    logic       idx2_len3;
    logic [7:0] b;
    t_state     nx;

    assign b = i_byte;

    // Sequence length from the held lead byte, and which continuation this is.
    always_comb begin
        len3      = (i_state.lead[7:4] == 4'he);
        len4      = (i_state.lead[7:3] == 5'h1e);
        idx1      = len3 ? (i_state.rem == 2'd2) :
                    len4 ? (i_state.rem == 2'd3) : (i_state.rem == 2'd1);
        idx2_len3 = len3 && (i_state.rem == 2'd1);
    end

    // Main decision for one byte.
    always_comb begin
        nx                    = i_state;
        bad                   = 1'b0;
        o_result.status       = ST_BUSY;
        o_result.error_offset = '0;
        if (i_state.skipping) begin
            o_result.status = ST_SKIP;
            if (b == BYTE_NUL) begin
                nx = STATE_RESET;
            end else begin
                nx.pos = adv_pos(i_state.pos);
            end
        end else if (i_state.rem == 2'd0) begin
            if (b == BYTE_NUL) begin
                o_result.status = ST_VALID;
                nx = STATE_RESET;
            end else if (b[7] == 1'b0) begin
                nx.pos = adv_pos(i_state.pos);
            end else if (b[7:5] == 3'b110) begin
                if (b[7:1] == 7'b1100000) begin
                    bad = 1'b1;
                end else begin
                    nx.rem = 2'd1;
                end
            end else if (b[7:4] == 4'he) begin
                nx.rem = 2'd2;
            end else if (b[7:3] == 5'h1e) begin
                if (b > LEAD_F4) begin
                    bad = 1'b1;
                end else begin
                    nx.rem = 2'd3;
                end
            end else begin
                bad = 1'b1;
            end
            if (bad) begin
                nx.seq_start = i_state.pos;
            end else if (nx.rem != 2'd0) begin
                nx.lead      = b;
                nx.second    = 8'd0;
                nx.seq_start = i_state.pos;
                nx.pos       = adv_pos(i_state.pos);
            end
        end else begin
            if (b[7:6] != 2'b10) begin
                bad = 1'b1;
            end else if (idx1) begin
                if ((i_state.lead == LEAD_E0 && b[7:5] == 3'b100) ||
                    (i_state.lead == LEAD_ED && b[7:5] == 3'b101) ||
                    (i_state.lead == LEAD_F0 && b[7:4] == 4'h8) ||
                    (i_state.lead == LEAD_F4 && b > 8'h8f)) begin
                    bad = 1'b1;
                end
                nx.second = b;
            end else if (idx2_len3) begin
                if (i_state.lead == LEAD_EF && i_state.second == CONT_BF &&
                    b[7:1] == 7'b1011111) begin
                    bad = 1'b1;
                end
            end
            if (!bad) begin
                nx.rem = i_state.rem - 2'd1;
                nx.pos = adv_pos(i_state.pos);
            end
        end

        // An error reports the sequence start, then ends or skips the string.
        if (bad) begin
            o_result.status       = ST_ERROR;
            o_result.error_offset = ERR_OFS_W'(nx.seq_start);
            if (b == BYTE_NUL) begin
                nx = STATE_RESET;
            end else begin
                nx.rem      = 2'd0;
                nx.skipping = 1'b1;
                nx.pos      = adv_pos(i_state.pos);
            end
        end
    end

    assign o_state = nx;

endmodule

[src/utf8_stream_validator_core.sv]
// An accepted input word passes the input register, then the result register, to the master side.
// Throughput: one byte per cycle; input register, checker logic and result register
// form a two-stage pipeline that stalls only when the result word is not taken.
// Reset: synchronous, active low; clears both stage valid flags and the checker
// state, so the first byte after reset starts a new string at offset 0.
// Top level of the UTF-8 stream validator.
`timescale 1ns / 1ps

`include "utf8_stream_validator_core_assert.svh"

module utf8_stream_validator_core
    import u8sv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata     // [1:0] status, [17:2] error_offset, [23:18] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;

    t_state     n_state;
    t_result    n_out;
    logic       advance;

    // The result register can take a word when empty or being emptied.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    u8sv_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Checker state and result register advance together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.error_offset, r_out.status};

    // Checks on the pipeline and checker state.
    `U8SV_ASSERT_NOW(a_offset_zero, r_out_valid && r_out.status != ST_ERROR, r_out.error_offset == '0, "offset set without error")
    `U8SV_ASSERT_NOW(a_skip_no_seq, r_state.skipping, r_state.rem == 2'd0, "open sequence while skipping")
    `U8SV_ASSERT_NEXT(a_in_held, r_in_valid && !advance, r_in_valid, "stalled input word lost")
    `U8SV_ASSERT_NEXT(a_valid_restart, advance && r_in_valid && n_out.status == ST_VALID, r_state.pos == '0 && !r_state.skipping, "no restart after valid end")

endmodule

[tb/sv/utf8_status_checker.sv]
// Checker for the UTF-8 stream validator: predicts the status of each byte and compares.
`timescale 1ns / 1ps

module utf8_status_checker
    import u8sv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // [1:0] status, [17:2] error_offset, [23:18] zero
    output int          o_fail_count,
    output int          o_pending
);

    // One predicted status word, with the byte that caused it for the log.
    typedef struct {
        t_result     res;
        logic [7:0]  data;
        int unsigned seq_no;
    } t_status_entry;

    t_status_entry status_q[$];
    t_state        vst;
    int unsigned   bytes_seen;
    int            mismatches;

    assign o_fail_count = mismatches;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Clears the string context; the next byte starts a string at offset 0.
    function automatic void restart_string();
        vst = STATE_RESET;
    endfunction

    // Saturating step of the byte position.
    function automatic void bump_pos();
        if (vst.pos != {OFFSET_BITS{1'b1}}) begin
            vst.pos = vst.pos + 1'b1;
        end
    endfunction

    // Predicts the status word for one byte and updates the checker state.
    function automatic t_result next_status(input logic [7:0] b);
        t_result     r;
        logic        bad;
        int unsigned seq_len;
        int unsigned idx;
        r.status       = ST_BUSY;
        r.error_offset = '0;
        bad            = 1'b0;

        if (vst.skipping) begin
            // Skipping to the end of a string that already failed.
            r.status = ST_SKIP;
            if (b == BYTE_NUL) begin
                restart_string();
            end else begin
                bump_pos();
            end
        end else if (vst.rem == 2'd0) begin
            // At a sequence boundary: NUL, ASCII or a lead byte.
            if (b == BYTE_NUL) begin
                r.status = ST_VALID;
                restart_string();
            end else if (b[7] == 1'b0) begin
                bump_pos();
            end else if (b[7:5] == 3'b110) begin
                if (b[7:1] == 7'b1100000) begin
                    bad = 1'b1;
                end else begin
                    vst.rem = 2'd1;
                end
            end else if (b[7:4] == 4'he) begin
                vst.rem = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                if (b > LEAD_F4) begin
                    bad = 1'b1;
                end else begin
                    vst.rem = 2'd3;
                end
            end else begin
                bad = 1'b1;
            end
            if (bad) begin
                vst.seq_start = vst.pos;
            end else if (vst.rem != 2'd0) begin
                vst.lead      = b;
                vst.second    = 8'd0;
                vst.seq_start = vst.pos;
                bump_pos();
            end
        end else begin
            // Inside a sequence: the byte must be a fitting continuation.
            if (vst.lead[7:4] == 4'he) begin
                seq_len = 3;
            end else if (vst.lead[7:3] == 5'b11110) begin
                seq_len = 4;
            end else begin
                seq_len = 2;
            end
            idx = seq_len - vst.rem;
            if (b[7:6] != 2'b10) begin
                bad = 1'b1;
            end else if (idx == 1) begin
                if ((vst.lead == LEAD_E0 && b[7:5] == 3'b100) ||
                    (vst.lead == LEAD_ED && b[7:5] == 3'b101) ||
                    (vst.lead == LEAD_F0 && b[7:4] == 4'h8) ||
                    (vst.lead == LEAD_F4 && b > 8'h8f)) begin
                    bad = 1'b1;
                end
                vst.second = b;
            end else if (idx == 2 && seq_len == 3) begin
                if (vst.lead == LEAD_EF && vst.second == CONT_BF && b[7:1] == 7'b1011111) begin
                    bad = 1'b1;
                end
            end
            if (!bad) begin
                vst.rem = vst.rem - 2'd1;
                bump_pos();
            end
        end

        // A failed sequence reports its lead offset; a NUL also ends the string.
        if (bad) begin
            r.status       = ST_ERROR;
            r.error_offset = ERR_OFS_W'(vst.seq_start);
            if (b == BYTE_NUL) begin
                restart_string();
            end else begin
                vst.rem      = 2'd0;
                vst.skipping = 1'b1;
                bump_pos();
            end
        end
        return r;
    endfunction

    // Watch both channels; predict on each input word, compare on each result word.
    always @(posedge i_clk) begin
        t_status_entry ent;
        t_status       got_status;
        logic [15:0]   got_offset;
        if (!i_rst_n) begin
            restart_string();
            status_q.delete();
            bytes_seen = 0;
            mismatches = mismatches;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                ent.res    = next_status(i_s_tdata);
                ent.data   = i_s_tdata;
                ent.seq_no = bytes_seen;
                bytes_seen++;
                status_q.push_back(ent);
            end
            if (i_m_tvalid && i_m_tready) begin
                got_status = t_status'(i_m_tdata[1:0]);
                got_offset = i_m_tdata[17:2];
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no byte outstanding",
                                              i_m_tdata));
                end else begin
                    ent = status_q.pop_front();
                    if (got_status != ent.res.status) begin
                        report_mismatch($sformatf("byte #%0d (%h): status %s, expected %s",
                                                  ent.seq_no, ent.data, got_status.name(),
                                                  ent.res.status.name()));
                    end
                    if (got_offset != ent.res.error_offset) begin
                        report_mismatch($sformatf("byte #%0d (%h): offset %0d, expected %0d",
                                                  ent.seq_no, ent.data, got_offset,
                                                  ent.res.error_offset));
                    end
                    if (i_m_tdata[23:18] != 6'd0) begin
                        report_mismatch($sformatf("byte #%0d (%h): padding bits %b not zero",
                                                  ent.seq_no, ent.data, i_m_tdata[23:18]));
                    end
                end
            end
        end
        o_pending <= status_q.size();
    end

    initial begin
        vst        = STATE_RESET;
        bytes_seen = 0;
        mismatches = 0;
        o_pending  = 0;
    end

endmodule

[tb/sv/testbench.sv]
// Top of the UTF-8 stream validator testbench: clock, reset, byte strings and verdict.
`timescale 1ns / 1ps

module testbench
    import u8sv_pkg::*;
();

    localparam int HOLD_CYCLES = 400;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;    // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [1:0] status, [17:2] error_offset, [23:18] zero

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit long_hold      = 1'b0;

    logic [7:0] str_q[$];

    always #6 clk = ~clk;

    utf8_stream_validator_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    utf8_status_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge clk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offers one byte, idling first at random, and returns once the word is taken.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_string();
        foreach (str_q[i]) begin
            send_byte(str_q[i]);
        end
    endtask

    // Stops offering and waits until every status word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    // Random value in a range that hits either end at least a quarter of the time each.
    function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    // Appends a sequence that fails one of the strict rules.
    function automatic void push_forbidden();
        case ($urandom_range(0, 7))
            0: str_q.push_back(pick(8'hc0, 8'hc1));
            1: begin
                str_q.push_back(LEAD_E0);
                str_q.push_back(pick(8'h80, 8'h9f));
            end
            2: begin
                str_q.push_back(LEAD_ED);
                str_q.push_back(pick(8'ha0, 8'hbf));
            end
            3: begin
                str_q.push_back(LEAD_EF);
                str_q.push_back(CONT_BF);
                str_q.push_back(pick(8'hbe, 8'hbf));
            end
            4: begin
                str_q.push_back(LEAD_F0);
                str_q.push_back(pick(8'h80, 8'h8f));
            end
            5: begin
                str_q.push_back(LEAD_F4);
                str_q.push_back(pick(8'h90, 8'hbf));
            end
            6: str_q.push_back(pick(8'hf5, 8'hff));
            default: str_q.push_back(pick(8'h80, 8'hbf));
        endcase
        // Sometimes the broken sequence carries on with continuations.
        repeat ($urandom_range(0, 2)) str_q.push_back(pick(8'h80, 8'hbf));
    endfunction

    // Appends one well-formed character, optionally damaged.
    function automatic void push_char(input bit damage);
        logic [7:0] c[4];
        int         n;
        int         at;
        case ($urandom_range(0, 3))
            0: begin
                n    = 1;
                c[0] = pick(8'h01, 8'h7f);
            end
            1: begin
                n    = 2;
                c[0] = pick(8'hc2, 8'hdf);
                c[1] = pick(8'h80, 8'hbf);
            end
            2: begin
                n    = 3;
                c[0] = ($urandom_range(0, 3) == 0) ? LEAD_ED : pick(8'he0, 8'hef);
                if (c[0] == LEAD_E0) begin
                    c[1] = pick(8'ha0, 8'hbf);
                end else if (c[0] == LEAD_ED) begin
                    c[1] = pick(8'h80, 8'h9f);
                end else begin
                    c[1] = pick(8'h80, 8'hbf);
                end
                if (c[0] == LEAD_EF && c[1] == CONT_BF) begin
                    c[2] = pick(8'h80, 8'hbd);
                end else begin
                    c[2] = pick(8'h80, 8'hbf);
                end
            end
            default: begin
                n    = 4;
                c[0] = pick(8'hf0, 8'hf4);
                if (c[0] == LEAD_F0) begin
                    c[1] = pick(8'h90, 8'hbf);
                end else if (c[0] == LEAD_F4) begin
                    c[1] = pick(8'h80, 8'h8f);
                end else begin
                    c[1] = pick(8'h80, 8'hbf);
                end
                c[2] = pick(8'h80, 8'hbf);
                c[3] = pick(8'h80, 8'hbf);
            end
        endcase
        if (damage) begin
            at = $urandom_range(0, n - 1);
            case ($urandom_range(0, 3))
                0: c[at] = BYTE_NUL;
                1: c[at] = 8'($urandom_range(0, 255));
                2: n = (at == 0) ? n : at;
                default: begin
                    push_forbidden();
                    n = 0;
                end
            endcase
        end
        for (int i = 0; i < n; i++) begin
            str_q.push_back(c[i]);
        end
    endfunction

    // Builds one string: mostly characters with random content, some pure noise.
    function automatic void build_string();
        str_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, 12)) str_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 10)) push_char($urandom_range(0, 7) == 0);
        end
        str_q.push_back(BYTE_NUL);
    endfunction

    task automatic run_random(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_string();
            sent += str_q.size();
            send_string();
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings: empty, extremes of the one-, two- and four-byte forms, and strict-rule failures.
        str_q = '{BYTE_NUL,
                  8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf, LEAD_F4, 8'h8f, 8'hbf, 8'hbf, BYTE_NUL,
                  8'hc0, 8'hff, BYTE_NUL,
                  LEAD_ED, 8'ha0, BYTE_NUL,
                  LEAD_EF, CONT_BF, 8'hbe, BYTE_NUL,
                  8'he1, BYTE_NUL,
                  8'h80, BYTE_NUL};
        send_string();
        drain();

        // No idling, then a string that fails midway and is skipped to its end.
        run_random(325);
        send_byte(8'hc3);
        send_byte(8'ha9);
        repeat (10) send_byte(8'h41);
        send_byte(8'hff);
        repeat (3) send_byte(8'h41);
        send_byte(BYTE_NUL);
        drain();

        // Slow sender.
        send_idle_pct = 74;
        run_random(325);
        drain();

        // Slow receiver, then a long hold-off while the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 74;
        run_random(325);
        long_hold = 1'b1;
        run_random(40);
        drain();

        // Light idling on both sides.
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        run_random(325);
        drain();

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/u8sv_pkg.sv
src/u8sv_step.sv
src/utf8_stream_validator_core.sv
tb/sv/utf8_status_checker.sv
tb/sv/testbench.sv
